// ===== sv/divergence_checkpoint_table_macros.svh =====
// ----------------------------------------------------------------------------
// divergence checkpoint table assertion macros
// Shorthand for clocked assertions with the block reset as disable condition.
// ----------------------------------------------------------------------------
`ifndef DIVERGENCE_CHECKPOINT_TABLE_MACROS_SVH
`define DIVERGENCE_CHECKPOINT_TABLE_MACROS_SVH

// overlapping implication, checked on every rising edge out of reset
`define DCT_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// implication into the following cycle
`define DCT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== sv/dct_pkg.sv =====
// ----------------------------------------------------------------------------
// dct_pkg
// Types and constants shared by the divergence checkpoint table.
// ----------------------------------------------------------------------------
package dct_pkg;

  localparam int KEY_BITS   = 10;
  localparam int VALUE_BITS = 32;
  localparam int SUM_BITS   = 48;
  localparam int THR_BITS   = 49;
  localparam int ID_BITS    = 16;
  localparam int CFG_IDX_BITS = 2;

  localparam logic [CFG_IDX_BITS-1:0] REG_THRESHOLD = CFG_IDX_BITS'(0);
  localparam logic [CFG_IDX_BITS-1:0] REG_BLOCK_ID  = CFG_IDX_BITS'(1);

  typedef struct packed {
    logic [KEY_BITS-1:0]          key;
    logic signed [VALUE_BITS-1:0] new_value;
    logic                         checkpoint_allowed;
  } dct_in_t;

  typedef struct packed {
    logic                         checkpoint_taken;
    logic [KEY_BITS-1:0]          saved_key;
    logic signed [VALUE_BITS-1:0] saved_value;
    logic [ID_BITS-1:0]           owner_id;
    logic [SUM_BITS-1:0]          divergence_total;
  } dct_out_t;

  // one table word: backup with its valid mark, and the current value
  typedef struct packed {
    logic                  valid;
    logic [VALUE_BITS-1:0] backup;
    logic [VALUE_BITS-1:0] current;
  } dct_entry_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DIST,
    ST_SUM,
    ST_CHK
  } dct_state_t;

endpackage

// ===== sv/dct_dist.sv =====
// ----------------------------------------------------------------------------
// dct_dist
// Absolute distance between two signed values, taken in offset binary.
// ----------------------------------------------------------------------------
module dct_dist (
  input  logic [dct_pkg::VALUE_BITS-1:0] a,
  input  logic [dct_pkg::VALUE_BITS-1:0] b,
  output logic [dct_pkg::VALUE_BITS-1:0] abs_diff
);
  import dct_pkg::*;

  localparam logic [VALUE_BITS-1:0] SIGN_BIT = {1'b1, {(VALUE_BITS-1){1'b0}}};

  logic [VALUE_BITS-1:0] ua;
  logic [VALUE_BITS-1:0] ub;

  // flipping the sign bit maps signed order onto unsigned order
  assign ua = a ^ SIGN_BIT;
  assign ub = b ^ SIGN_BIT;
  assign abs_diff = (ua >= ub) ? (ua - ub) : (ub - ua);

endmodule

// ===== sv/divergence_checkpoint_table.sv =====
// ----------------------------------------------------------------------------
// divergence_checkpoint_table
// Keyed value table with checkpoint backups and a running divergence total.
// ----------------------------------------------------------------------------
// After reset the block sweeps its 1024-entry table, one entry per cycle, and
// takes no update until the sweep is done (register writes are taken at
// any time). Each update then runs in steps: the table is read at the
// transfer edge, then the two distances are registered, then the total
// update, then the threshold check with table write-back, which waits while
// the output register is full and stalled. The read-modify-write of one
// entry at a time keeps a single update in flight; the next update is
// taken once the result has been loaded into the output register, even
// while that result still waits to be taken.
module divergence_checkpoint_table (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  dct_pkg::dct_in_t                in_data,
  output logic                            out_valid,
  input  logic                            out_stall,
  output dct_pkg::dct_out_t               out_data,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [dct_pkg::CFG_IDX_BITS-1:0] cfg_index,
  input  logic [dct_pkg::THR_BITS-1:0]    cfg_data
);
  import dct_pkg::*;

  localparam int DEPTH = 1 << KEY_BITS;

  dct_state_t state_r, state_nxt;

  dct_entry_t mem [DEPTH];
  dct_entry_t rd_data_r;
  dct_entry_t wr_data;
  logic [KEY_BITS-1:0] wr_addr;
  logic                wr_en;

  logic [KEY_BITS-1:0] clr_idx_r;
  dct_in_t             item_r;
  logic [THR_BITS-1:0] thr_r;
  logic [ID_BITS-1:0]  block_id_r;
  logic [SUM_BITS-1:0] sum_r;
  logic [SUM_BITS-1:0] sum_mid_r;
  logic [VALUE_BITS-1:0] d_old_r;
  logic [VALUE_BITS-1:0] d_new_r;

  logic                out_valid_r;
  dct_out_t            out_data_r;

  logic [VALUE_BITS-1:0] ref_val;
  logic [VALUE_BITS-1:0] d_old;
  logic [VALUE_BITS-1:0] d_new;
  logic [SUM_BITS-1:0]   d_new_ext;
  logic [SUM_BITS-1:0]   sum_fin;
  logic                  take;
  logic                  in_xfer;
  logic                  out_free;
  logic                  finish;

  // entry with no backup compares against zero
  assign ref_val = rd_data_r.valid ? rd_data_r.backup : '0;

  dct_dist u_dist_old (
    .a        (rd_data_r.current),
    .b        (ref_val),
    .abs_diff (d_old)
  );

  dct_dist u_dist_new (
    .a        (item_r.new_value),
    .b        (ref_val),
    .abs_diff (d_new)
  );

  assign d_new_ext = {{(SUM_BITS-VALUE_BITS){1'b0}}, d_new_r};
  assign take = item_r.checkpoint_allowed && !thr_r[THR_BITS-1] &&
                (sum_mid_r > thr_r[SUM_BITS-1:0]);
  assign sum_fin = take ? (sum_mid_r - d_new_ext) : sum_mid_r;

  assign out_free = !out_valid_r || !out_stall;
  assign in_stall = (state_r != ST_IDLE);
  assign in_xfer  = in_valid && !in_stall;
  assign cfg_ready = 1'b1;

  always_comb begin
    state_nxt = state_r;
    wr_en     = 1'b0;
    wr_addr   = item_r.key;
    wr_data   = '0;
    finish    = 1'b0;
    case (state_r)
      ST_CLEAR: begin
        wr_en   = 1'b1;
        wr_addr = clr_idx_r;
        if (clr_idx_r == {KEY_BITS{1'b1}}) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_xfer) begin
          state_nxt = ST_DIST;
        end
      end
      ST_DIST: begin
        state_nxt = ST_SUM;
      end
      ST_SUM: begin
        state_nxt = ST_CHK;
      end
      ST_CHK: begin
        if (out_free) begin
          finish          = 1'b1;
          wr_en           = 1'b1;
          wr_data.current = item_r.new_value;
          wr_data.valid   = take ? 1'b1 : rd_data_r.valid;
          wr_data.backup  = take ? item_r.new_value : rd_data_r.backup;
          state_nxt       = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  // table memory, one write and one registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (in_xfer) begin
      rd_data_r <= mem[in_data.key];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_idx_r   <= '0;
      thr_r       <= '1;
      block_id_r  <= '0;
      sum_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (state_r == ST_CLEAR) begin
        clr_idx_r <= clr_idx_r + 1'b1;
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_THRESHOLD: thr_r      <= cfg_data;
          REG_BLOCK_ID:  block_id_r <= cfg_data[ID_BITS-1:0];
          default: ;
        endcase
      end
      if (finish) begin
        sum_r       <= sum_fin;
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      item_r <= in_data;
    end
    if (state_r == ST_DIST) begin
      d_old_r <= d_old;
      d_new_r <= d_new;
    end
    if (state_r == ST_SUM) begin
      sum_mid_r <= sum_r - {{(SUM_BITS-VALUE_BITS){1'b0}}, d_old_r} + d_new_ext;
    end
    if (finish) begin
      out_data_r.checkpoint_taken <= take;
      out_data_r.saved_key        <= item_r.key;
      out_data_r.saved_value      <= item_r.new_value;
      out_data_r.owner_id         <= take ? block_id_r : '0;
      out_data_r.divergence_total <= sum_fin;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ===== sv/dct_checker.sv =====
// ----------------------------------------------------------------------------
// dct_checker
// Port-level checks for the divergence checkpoint table, bound to the top.
// ----------------------------------------------------------------------------
`include "divergence_checkpoint_table_macros.svh"

module dct_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_stall,
  input logic              out_valid,
  input logic              out_stall,
  input dct_pkg::dct_out_t out_data
);
  import dct_pkg::*;

  // a stalled result stays put
  `DCT_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_data), "result changed while stalled")

  // one update in flight: the input closes right after a transfer
  `DCT_ASSERT_NEXT(a_one_in_flight, in_valid && !in_stall, in_stall, "second update taken while busy")

  // owner id only goes out with a save
  `DCT_ASSERT_NOW(a_owner_zero, out_valid && !out_data.checkpoint_taken, out_data.owner_id == '0, "owner id without checkpoint")

endmodule

bind divergence_checkpoint_table dct_checker u_dct_checker (.*);
